FILE: hdl/gsn_pkg.sv
// Shared types and constants for the grid surface normal block.
// No dependencies; every other file refers to it by scoped names.
package gsn_pkg;

  localparam int COORD_W  = 16;               // vertex coordinate width
  localparam int VTX_W    = 3 * COORD_W;      // one packed vertex
  localparam int DIFF_W   = COORD_W + 1;      // exact forward difference
  localparam int PROD_W   = 2 * DIFF_W;       // one partial product
  localparam int CROSS_W  = PROD_W + 1;       // signed cross component
  localparam int MAG_W    = CROSS_W - 1;      // its magnitude
  localparam int NORM_W   = 30;               // normalized range [2^29, 2^30)
  localparam int SQ_W     = 64;               // root working width
  localparam int LEN_W    = 31;               // vector length
  localparam int REM_W    = LEN_W + 1;        // divider remainder
  localparam int Q_W      = 15;               // quotient, up to 16384
  localparam int NRM_W    = 16;               // output component width
  localparam int TILE_W   = 8;                // tiles registers and counters
  localparam int LS_DEPTH = 1 << TILE_W;      // line store entries
  localparam int STEP_W   = 4;

  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(5);
  localparam logic [STEP_W-1:0] SQR_LAST = STEP_W'(2);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(Q_W - 1);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_TILES_X = 1'b0;
  localparam logic REG_TILES_Y = 1'b1;
  localparam logic [TILE_W-1:0] TILES_RST = TILE_W'(16);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL, S_ABS, S_NORM, S_SQR, S_SQRT, S_DIV, S_DONE
  } gsn_state_t;

  typedef struct packed {
    logic accept;
    logic diff;
    logic mul_step;
    logic abs_step;
    logic norm_step;
    logic sqr_step;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } gsn_cmd_t;

  typedef struct packed {
    logic need;
    logic mul_last;
    logic zero;
    logic norm_done;
    logic sqr_last;
    logic sqrt_done;
    logic div_last;
    logic out_free;
  } gsn_sts_t;

endpackage

FILE: hdl/gsn_ifs.sv
// Request channel interfaces: vertex input and normal output.
// Depends on gsn_pkg for field widths.
interface gsn_in_if;
  logic valid;
  logic ready;
  logic signed [gsn_pkg::COORD_W-1:0] px;
  logic signed [gsn_pkg::COORD_W-1:0] py;
  logic signed [gsn_pkg::COORD_W-1:0] pz;
  modport source (output valid, px, py, pz, input ready);
  modport sink (input valid, px, py, pz, output ready);
endinterface

interface gsn_out_if;
  logic valid;
  logic ready;
  logic signed [gsn_pkg::NRM_W-1:0] nx;
  logic signed [gsn_pkg::NRM_W-1:0] ny;
  logic signed [gsn_pkg::NRM_W-1:0] nz;
  logic [gsn_pkg::TILE_W-1:0] col;
  logic [gsn_pkg::TILE_W-1:0] row;
  logic degenerate;
  logic frame_last;
  modport source (output valid, nx, ny, nz, col, row, degenerate, frame_last, input ready);
  modport sink (input valid, nx, ny, nz, col, row, degenerate, frame_last, output ready);
endinterface

FILE: hdl/gsn_ctrl.sv
// Sequencer for the normal computation.
// Depends on gsn_pkg (state, command and status types).
module gsn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gsn_pkg::gsn_sts_t   sts,
  output gsn_pkg::gsn_cmd_t   cmd,
  output gsn_pkg::gsn_state_t state
);

  gsn_pkg::gsn_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= gsn_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      gsn_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.need) state_nxt = gsn_pkg::S_DIFF;
        end
      end
      gsn_pkg::S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = gsn_pkg::S_MUL;
      end
      gsn_pkg::S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = gsn_pkg::S_ABS;
      end
      gsn_pkg::S_ABS: begin
        cmd.abs_step = 1'b1;
        state_nxt    = sts.zero ? gsn_pkg::S_DONE : gsn_pkg::S_NORM;
      end
      gsn_pkg::S_NORM: begin
        if (sts.norm_done) state_nxt = gsn_pkg::S_SQR;
        else cmd.norm_step = 1'b1;
      end
      gsn_pkg::S_SQR: begin
        cmd.sqr_step = 1'b1;
        if (sts.sqr_last) state_nxt = gsn_pkg::S_SQRT;
      end
      gsn_pkg::S_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = gsn_pkg::S_DIV;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      gsn_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = gsn_pkg::S_DONE;
      end
      gsn_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = gsn_pkg::S_IDLE;
        end
      end
      default: state_nxt = gsn_pkg::S_IDLE;
    endcase
  end

  assign state = state_r;

endmodule

FILE: hdl/gsn_dp.sv
// Datapath: line store, grid position, cross product, normalize,
// square root, three-lane divider and output register. Depends on gsn_pkg.
module gsn_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gsn_pkg::gsn_cmd_t                 cmd,
  output gsn_pkg::gsn_sts_t                 sts,
  input  logic [gsn_pkg::TILE_W-1:0]        tiles_x,
  input  logic [gsn_pkg::TILE_W-1:0]        tiles_y,
  input  logic                              pos_clr,
  input  logic [gsn_pkg::COORD_W-1:0]       px,
  input  logic [gsn_pkg::COORD_W-1:0]       py,
  input  logic [gsn_pkg::COORD_W-1:0]       pz,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [gsn_pkg::NRM_W-1:0]  nx,
  output logic signed [gsn_pkg::NRM_W-1:0]  ny,
  output logic signed [gsn_pkg::NRM_W-1:0]  nz,
  output logic [gsn_pkg::TILE_W-1:0]        col,
  output logic [gsn_pkg::TILE_W-1:0]        row,
  output logic                              degenerate,
  output logic                              frame_last
);

  localparam int CW = gsn_pkg::COORD_W;
  localparam int TW = gsn_pkg::TILE_W;

  // ---------------- position and line store ----------------
  logic [TW-1:0] col_r, row_r;
  logic [TW-1:0] col_eff, col_nxt, row_nxt, rd1_addr;
  logic [TW:0]   col_inc, row_inc;

  always_comb begin
    col_eff  = (col_r > tiles_x) ? '0 : col_r;
    rd1_addr = col_eff + TW'(1);
    col_inc  = {1'b0, col_eff} + (TW+1)'(1);
    row_inc  = {1'b0, row_r} + (TW+1)'(1);
    if (col_inc > {1'b0, tiles_x}) begin
      col_nxt = '0;
      row_nxt = (row_inc > {1'b0, tiles_y}) ? '0 : row_inc[TW-1:0];
    end else begin
      col_nxt = col_inc[TW-1:0];
      row_nxt = (row_r > tiles_y) ? '0 : row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (pos_clr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  logic [gsn_pkg::VTX_W-1:0] ls_mem [gsn_pkg::LS_DEPTH];
  logic [gsn_pkg::VTX_W-1:0] rd0_r, rd1_r, cur_r;
  logic [TW-1:0] mcol_r, mrow_r;
  logic          mlast_r;

  // read-before-write: entry col still holds the previous row here
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd0_r           <= ls_mem[col_eff];
      rd1_r           <= ls_mem[rd1_addr];
      ls_mem[col_eff] <= {pz, py, px};
      cur_r           <= {pz, py, px};
      mcol_r          <= col_eff;
      mrow_r          <= row_r - TW'(1);
      mlast_r         <= (col_inc == {1'b0, tiles_x}) && (row_r == tiles_y);
    end
  end

  // ---------------- differences and cross product ----------------
  localparam int STEP_W_L = gsn_pkg::STEP_W;
  logic signed [gsn_pkg::DIFF_W-1:0]  d_r [6];
  logic signed [gsn_pkg::CROSS_W-1:0] c_r [3];
  logic [STEP_W_L-1:0] step_r;

  logic signed [gsn_pkg::DIFF_W-1:0] op_a, op_b;
  logic signed [gsn_pkg::PROD_W-1:0] prod;

  always_comb begin
    case (step_r)
      4'd0:    begin op_a = d_r[1]; op_b = d_r[5]; end
      4'd1:    begin op_a = d_r[2]; op_b = d_r[4]; end
      4'd2:    begin op_a = d_r[2]; op_b = d_r[3]; end
      4'd3:    begin op_a = d_r[0]; op_b = d_r[5]; end
      4'd4:    begin op_a = d_r[0]; op_b = d_r[4]; end
      4'd5:    begin op_a = d_r[1]; op_b = d_r[3]; end
      default: begin op_a = '0;     op_b = '0;     end
    endcase
    prod = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= $signed({rd1_r[CW*i+CW-1], rd1_r[CW*i +: CW]})
                  - $signed({rd0_r[CW*i+CW-1], rd0_r[CW*i +: CW]});
        d_r[i+3] <= $signed({cur_r[CW*i+CW-1], cur_r[CW*i +: CW]})
                  - $signed({rd0_r[CW*i+CW-1], rd0_r[CW*i +: CW]});
      end
    end
    if (cmd.mul_step) begin
      for (int k = 0; k < 3; k++) begin
        if (step_r[2:1] == 2'(k)) begin
          if (!step_r[0]) c_r[k] <= gsn_pkg::CROSS_W'(prod);
          else c_r[k] <= c_r[k] - gsn_pkg::CROSS_W'(prod);
        end
      end
    end
  end

  // ---------------- sign/magnitude and normalize ----------------
  logic [gsn_pkg::MAG_W-1:0] cm_r [3];
  logic [gsn_pkg::MAG_W-1:0] cm_abs [3];
  logic [gsn_pkg::MAG_W-1:0] m_abs, m_r;
  logic [2:0] cs_r;
  logic       deg_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm_abs[i] = c_r[i][gsn_pkg::CROSS_W-1] ? gsn_pkg::MAG_W'(-c_r[i])
                                              : gsn_pkg::MAG_W'(c_r[i]);
    end
    m_abs = cm_abs[0];
    if (cm_abs[1] > m_abs) m_abs = cm_abs[1];
    if (cm_abs[2] > m_abs) m_abs = cm_abs[2];
  end

  logic m_high, m_tiny, m_low;
  assign m_high = |m_r[gsn_pkg::MAG_W-1:gsn_pkg::NORM_W];
  assign m_tiny = ~|m_r[gsn_pkg::MAG_W-1:gsn_pkg::NORM_W-4];
  assign m_low  = ~m_high & ~m_r[gsn_pkg::NORM_W-1];

  always_ff @(posedge clk) begin
    if (cmd.abs_step) begin
      for (int i = 0; i < 3; i++) begin
        cm_r[i] <= cm_abs[i];
        cs_r[i] <= c_r[i][gsn_pkg::CROSS_W-1];
      end
      m_r   <= m_abs;
      deg_r <= (m_abs == '0);
    end else if (cmd.norm_step) begin
      // right shifts drop bits one at a time; left shifts are exact
      if (m_high) begin
        m_r <= m_r >> 1;
        for (int i = 0; i < 3; i++) cm_r[i] <= cm_r[i] >> 1;
      end else if (m_tiny) begin
        m_r <= m_r << 4;
        for (int i = 0; i < 3; i++) cm_r[i] <= cm_r[i] << 4;
      end else if (m_low) begin
        m_r <= m_r << 1;
        for (int i = 0; i < 3; i++) cm_r[i] <= cm_r[i] << 1;
      end
    end
  end

  // ---------------- sum of squares and square root ----------------
  logic [gsn_pkg::NORM_W-1:0]   sq_op;
  logic [2*gsn_pkg::NORM_W-1:0] sq;
  logic [gsn_pkg::SQ_W-1:0]     sv_r, sr_r, sb_r, st;

  always_comb begin
    case (step_r)
      4'd0:    sq_op = cm_r[0][gsn_pkg::NORM_W-1:0];
      4'd1:    sq_op = cm_r[1][gsn_pkg::NORM_W-1:0];
      4'd2:    sq_op = cm_r[2][gsn_pkg::NORM_W-1:0];
      default: sq_op = '0;
    endcase
    sq = sq_op * sq_op;
    st = sr_r + sb_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.sqr_step) begin
      if (step_r == '0) begin
        sv_r <= gsn_pkg::SQ_W'(sq);
        sr_r <= '0;
        sb_r <= gsn_pkg::SQ_W'(1) << (gsn_pkg::SQ_W - 2);
      end else begin
        sv_r <= sv_r + gsn_pkg::SQ_W'(sq);
      end
    end else if (cmd.sqrt_step) begin
      if (sv_r >= st) begin
        sv_r <= sv_r - st;
        sr_r <= (sr_r >> 1) + sb_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sb_r <= sb_r >> 2;
    end
  end

  // ---------------- three-lane restoring divider ----------------
  logic [gsn_pkg::LEN_W-1:0] len_r;
  logic [gsn_pkg::REM_W-1:0] rem_r [3];
  logic [gsn_pkg::Q_W-1:0]   q_r [3];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      len_r <= sr_r[gsn_pkg::LEN_W-1:0];
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= gsn_pkg::REM_W'(cm_r[i][gsn_pkg::NORM_W-1:0]);
        q_r[i]   <= '0;
      end
    end else if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        if (rem_r[i] >= {1'b0, len_r}) begin
          rem_r[i] <= (rem_r[i] - {1'b0, len_r}) << 1;
          q_r[i]   <= {q_r[i][gsn_pkg::Q_W-2:0], 1'b1};
        end else begin
          rem_r[i] <= rem_r[i] << 1;
          q_r[i]   <= {q_r[i][gsn_pkg::Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- shared step counter ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.mul_step) begin
      step_r <= (step_r == gsn_pkg::MUL_LAST) ? '0 : step_r + STEP_W_L'(1);
    end else if (cmd.sqr_step) begin
      step_r <= (step_r == gsn_pkg::SQR_LAST) ? '0 : step_r + STEP_W_L'(1);
    end else if (cmd.div_step) begin
      step_r <= (step_r == gsn_pkg::DIV_LAST) ? '0 : step_r + STEP_W_L'(1);
    end
  end

  // ---------------- output register ----------------
  logic signed [gsn_pkg::NRM_W-1:0] n_val [3];
  logic signed [gsn_pkg::NRM_W-1:0] n_r [3];
  logic out_valid_r, col_dummy;
  logic [TW-1:0] ocol_r, orow_r;
  logic odeg_r, olast_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (deg_r) n_val[i] = '0;
      else if (cs_r[i]) n_val[i] = -$signed({1'b0, q_r[i]});
      else n_val[i] = $signed({1'b0, q_r[i]});
    end
    col_dummy = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int i = 0; i < 3; i++) n_r[i] <= n_val[i];
      ocol_r  <= mcol_r;
      orow_r  <= mrow_r;
      odeg_r  <= deg_r;
      olast_r <= mlast_r | col_dummy;
    end
  end

  assign out_valid  = out_valid_r;
  assign nx         = n_r[0];
  assign ny         = n_r[1];
  assign nz         = n_r[2];
  assign col        = ocol_r;
  assign row        = orow_r;
  assign degenerate = odeg_r;
  assign frame_last = olast_r;

  // ---------------- status ----------------
  always_comb begin
    sts.need      = (row_r != '0) && (col_eff < tiles_x);
    sts.mul_last  = (step_r == gsn_pkg::MUL_LAST);
    sts.zero      = (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
    sts.norm_done = ~m_high & m_r[gsn_pkg::NORM_W-1];
    sts.sqr_last  = (step_r == gsn_pkg::SQR_LAST);
    sts.sqrt_done = (sb_r == '0);
    sts.div_last  = (step_r == gsn_pkg::DIV_LAST);
    sts.out_free  = ~out_valid_r | out_ready;
  end

endmodule

FILE: hdl/grid_surface_normals.sv
// Grid surface normals: top level with APB-style register port.
// A vertex with no normal goes straight back to idle; a degenerate normal skips
// normalize, root and divider; others pass the 32-step bit-serial square root and
// the 15-step divider before the output register. One vertex at a time.
// Reset (rst_n low, synchronous): tiles_x = tiles_y = 16, position (0,0),
// output empty. Line store contents are undefined until written.
module grid_surface_normals (
  input  logic                          clk,
  input  logic                          rst_n,
  gsn_in_if.sink                        in_chan,
  gsn_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gsn_pkg::CFG_AW-1:0]    paddr,
  input  logic [gsn_pkg::CFG_DW-1:0]    pwdata,
  output logic [gsn_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  // Configuration registers; any write restarts the frame position.
  logic [gsn_pkg::TILE_W-1:0] tiles_x_r, tiles_y_r;
  logic cfg_wr;
  logic reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiles_x_r <= gsn_pkg::TILES_RST;
      tiles_y_r <= gsn_pkg::TILES_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        gsn_pkg::REG_TILES_X: tiles_x_r <= pwdata[gsn_pkg::TILE_W-1:0];
        gsn_pkg::REG_TILES_Y: tiles_y_r <= pwdata[gsn_pkg::TILE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      gsn_pkg::REG_TILES_X: prdata = gsn_pkg::CFG_DW'(tiles_x_r);
      gsn_pkg::REG_TILES_Y: prdata = gsn_pkg::CFG_DW'(tiles_y_r);
      default:              prdata = '0;
    endcase
  end

  gsn_pkg::gsn_cmd_t   cmd;
  gsn_pkg::gsn_sts_t   sts;
  gsn_pkg::gsn_state_t state;

  // Controller: accepts a request only from idle and, when it makes a normal,
  // walks the difference / multiply / normalize / root / divide sequence.
  gsn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  // Datapath: the output register lets the next request in while a
  // finished normal still waits downstream.
  gsn_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .tiles_x    (tiles_x_r),
    .tiles_y    (tiles_y_r),
    .pos_clr    (cfg_wr),
    .px         (in_chan.px),
    .py         (in_chan.py),
    .pz         (in_chan.pz),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .nx         (out_chan.nx),
    .ny         (out_chan.ny),
    .nz         (out_chan.nz),
    .col        (out_chan.col),
    .row        (out_chan.row),
    .degenerate (out_chan.degenerate),
    .frame_last (out_chan.frame_last)
  );

  // A request that makes no normal leaves the controller idle.
  a_no_work_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && !sts.need) |=> (state == gsn_pkg::S_IDLE))
    else $error("controller left idle on a request without a normal");

  // The output register is never overwritten while it holds an untaken normal.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_chan.valid || out_chan.ready))
    else $error("output register overwritten");

  // A degenerate normal carries zero components.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.degenerate) |->
      (out_chan.nx == '0 && out_chan.ny == '0 && out_chan.nz == '0))
    else $error("degenerate normal with nonzero components");

endmodule
